// ===== design/can_lidar_frame_reassembler_defines.svh =====
// Assertion helpers for the lidar reassembler.
`ifndef CAN_LIDAR_FRAME_REASSEMBLER_DEFINES_SVH
`define CAN_LIDAR_FRAME_REASSEMBLER_DEFINES_SVH

// Condition checked on every clock edge outside reset.
`define CLFR_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Trigger on one edge implies a condition on the next edge.
`define CLFR_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

// ===== design/clfr_pkg.sv =====
package clfr_pkg;

  // Input word: one CAN frame or one sector read.
  typedef struct packed {
    logic        mode;
    logic [28:0] frame_id;
    logic        is_extended;
    logic [3:0]  byte_count;
    logic [63:0] frame_data;
    logic [8:0]  sector_index;
  } in_t;

  // Result word.
  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] distance_raw;
    logic        distance_valid;
  } out_t;

  localparam logic [2:0] STATUS_IGNORED    = 3'd0;
  localparam logic [2:0] STATUS_COLLECTING = 3'd1;
  localparam logic [2:0] STATUS_PUBLISHED  = 3'd2;
  localparam logic [2:0] STATUS_BAD_FOOTER = 3'd3;
  localparam logic [2:0] STATUS_SECTOR     = 3'd4;

  localparam logic MODE_FRAME = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  // Configuration register indexes.
  localparam logic [2:0] REG_LIDAR_FRAME_ID = 3'd0;
  localparam logic [2:0] REG_HEADER_FIRST   = 3'd1;
  localparam logic [2:0] REG_HEADER_SECOND  = 3'd2;
  localparam logic [2:0] REG_FOOTER_VALUE   = 3'd3;
  localparam logic [2:0] REG_MIN_DISTANCE   = 3'd4;
  localparam logic [2:0] REG_UPSIDE_DOWN    = 3'd5;

  // Register reset values.
  localparam logic [28:0] RST_LIDAR_FRAME_ID = 29'h010;
  localparam logic [7:0]  RST_HEADER_FIRST   = 8'd170;
  localparam logic [7:0]  RST_HEADER_SECOND  = 8'd85;
  localparam logic [7:0]  RST_FOOTER_VALUE   = 8'd254;
  localparam logic [15:0] RST_MIN_DISTANCE   = 16'h0050;

  localparam logic [15:0] DIST_INVALID = 16'hFFFF;
  localparam logic [10:0] STD_ID_MASK  = 11'h7FF;
  localparam logic [3:0]  MAX_BYTES    = 4'd8;
  localparam logic [3:0]  HEADER_BYTES = 4'd2;

  localparam int LANES = 8;

endpackage

// ===== design/can_lidar_frame_reassembler.sv =====
// Channel  | Handshake                      | Payload
// ---------+--------------------------------+--------------------------------
// in       | in_valid / in_ready            | in_data  (clfr_pkg::in_t)
// out      | out_valid / out_ready          | out_data (clfr_pkg::out_t)
// cfg      | cfg_valid / cfg_ready (tied 1) | cfg_index, cfg_data
//
// One word accepted per cycle while out is not stalled; a taken word passes stage one, then the output register.
// Per-word work is bounded by one write and one read per byte lane of the store.
// rst is synchronous, active high; stores need no clearing pass after reset.
// A stalled output holds its word; one more word is still taken into stage one.
// in_ready drops only when both stage one and the output register are full.
`include "can_lidar_frame_reassembler_defines.svh"

module can_lidar_frame_reassembler
  import clfr_pkg::*;
#(
  parameter int SECTOR_COUNT = 360
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [28:0] cfg_data
);

  // Message: sync byte pair, one pad byte, 2 bytes per sector, then the footer.
  localparam int MSG_SIZE = 2 * SECTOR_COUNT + 4;
  localparam int FILL_W   = $clog2(MSG_SIZE + 1);
  // Position math width: fill plus one frame, and any 9-bit sector read.
  localparam int CW       = (FILL_W + 1 > 11) ? FILL_W + 1 : 11;
  // Byte lanes: position p sits in lane p%8, row p/8.
  localparam int ROWS     = (MSG_SIZE + LANES - 1) / LANES;
  localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
  // Two banks per lane (assembly / published), bank is the address MSB.
  localparam int LANE_DEPTH = 2 << ROW_W;

  // Configuration registers.
  logic [28:0] lidar_frame_id;
  logic [7:0]  header_first;
  logic [7:0]  header_second;
  logic [7:0]  footer_value;
  logic [15:0] min_distance;
  logic        upside_down;

  // Assembly state.
  logic              header_seen;
  logic [FILL_W-1:0] fill_index;
  logic              message_present;
  logic              pub_bank;     // bank holding the published message

  // Pipeline control.
  logic in_fire;
  logic s1_valid;
  logic s1_move;

  // Stage one (carries registered memory read data).
  logic       s1_is_read;
  logic [2:0] s1_status;
  logic       s1_rd_ok;
  logic [2:0] s1_lo_lane;
  logic [2:0] s1_hi_lane;
  logic [7:0] rdata [LANES];

  // Frame decode.
  logic [28:0]       id_masked;
  logic [3:0]        cnt;
  logic              id_match;
  logic              is_header;
  logic              hdr_active;
  logic              frame_take;
  logic [FILL_W-1:0] base;
  logic [CW-1:0]     fill_sum;
  logic              done;
  logic [CW-1:0]     foot_off;
  logic [7:0]        foot_byte;
  logic              foot_ok;
  logic [2:0]        frame_status;
  logic              frame_fire;
  logic              pub_fire;

  // Lane write/read ports.
  logic [2:0]     lane_k   [LANES];
  logic [CW-1:0]  lane_pos [LANES];
  logic           wen      [LANES];
  logic [ROW_W:0] waddr    [LANES];
  logic [7:0]     wdata    [LANES];
  logic [ROW_W:0] raddr    [LANES];

  // Read decode.
  logic [CW-1:0] s_ext;
  logic          in_range;
  logic [CW-1:0] sec;
  logic [CW-1:0] rpos;
  logic [CW-1:0] rpos1;

  // Output combine.
  logic [15:0] dist_word;
  logic        dist_ok;

  assign cfg_ready = 1'b1;
  assign s1_move   = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || s1_move;
  assign in_fire   = in_valid && in_ready;

  // ---------------------------------------------------------------------------
  // Configuration writes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      lidar_frame_id <= RST_LIDAR_FRAME_ID;
      header_first   <= RST_HEADER_FIRST;
      header_second  <= RST_HEADER_SECOND;
      footer_value   <= RST_FOOTER_VALUE;
      min_distance   <= RST_MIN_DISTANCE;
      upside_down    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LIDAR_FRAME_ID: lidar_frame_id <= cfg_data;
        REG_HEADER_FIRST:   header_first   <= cfg_data[7:0];
        REG_HEADER_SECOND:  header_second  <= cfg_data[7:0];
        REG_FOOTER_VALUE:   footer_value   <= cfg_data[7:0];
        REG_MIN_DISTANCE:   min_distance   <= cfg_data[15:0];
        REG_UPSIDE_DOWN:    upside_down    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Frame decode: match, header, append, completion
  // ---------------------------------------------------------------------------
  always_comb begin
    id_masked = in_data.is_extended ? in_data.frame_id
                                    : {18'd0, in_data.frame_id[10:0] & STD_ID_MASK};
    id_match  = (id_masked == lidar_frame_id);
    cnt       = (in_data.byte_count > MAX_BYTES) ? MAX_BYTES : in_data.byte_count;
    is_header = (cnt >= HEADER_BYTES) &&
                (in_data.frame_data[7:0] == header_first) &&
                (in_data.frame_data[15:8] == header_second);
    // A header restarts the fill at zero.
    hdr_active = header_seen || is_header;
    base       = is_header ? '0 : fill_index;
    frame_take = id_match && hdr_active;
    fill_sum   = CW'(base) + CW'(cnt);
    done       = (fill_sum >= CW'(MSG_SIZE));
    // Last message byte always lands in the completing frame.
    foot_off   = CW'(MSG_SIZE - 1) - CW'(base);
    foot_byte  = in_data.frame_data[{foot_off[2:0], 3'b000} +: 8];
    foot_ok    = (foot_byte == footer_value);

    if (!frame_take) begin
      frame_status = STATUS_IGNORED;
    end else if (!done) begin
      frame_status = STATUS_COLLECTING;
    end else if (foot_ok) begin
      frame_status = STATUS_PUBLISHED;
    end else begin
      frame_status = STATUS_BAD_FOOTER;
    end
  end

  assign frame_fire = in_fire && (in_data.mode == MODE_FRAME) && frame_take;
  assign pub_fire   = frame_fire && done && foot_ok;

  // ---------------------------------------------------------------------------
  // Sector read address
  // ---------------------------------------------------------------------------
  always_comb begin
    s_ext    = CW'(in_data.sector_index);
    in_range = (s_ext < CW'(SECTOR_COUNT));
    sec      = upside_down ? (CW'(SECTOR_COUNT - 1) - s_ext) : s_ext;
    rpos     = CW'(3) + {sec[CW-2:0], 1'b0};
    rpos1    = rpos + CW'(1);
  end

  // ---------------------------------------------------------------------------
  // Lane ports: each lane takes at most one byte of a frame
  // ---------------------------------------------------------------------------
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      lane_k[l]   = 3'(l) - base[2:0];
      lane_pos[l] = CW'(base) + CW'(lane_k[l]);
      wen[l]      = frame_fire && ({1'b0, lane_k[l]} < cnt) &&
                    (lane_pos[l] < CW'(MSG_SIZE));
      waddr[l]    = {~pub_bank, lane_pos[l][ROW_W+2:3]};
      wdata[l]    = in_data.frame_data[{lane_k[l], 3'b000} +: 8];
      raddr[l]    = {pub_bank, (rpos[2:0] == 3'(l)) ? rpos[ROW_W+2:3]
                                                    : rpos1[ROW_W+2:3]};
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    logic [7:0] lane_mem [LANE_DEPTH];

    always_ff @(posedge clk) begin
      if (wen[g]) begin
        lane_mem[waddr[g]] <= wdata[g];
      end
      if (in_fire) begin
        rdata[g] <= lane_mem[raddr[g]];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Assembly state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      header_seen     <= 1'b0;
      fill_index      <= '0;
      message_present <= 1'b0;
      pub_bank        <= 1'b0;
    end else if (frame_fire) begin
      if (done) begin
        fill_index  <= FILL_W'(MSG_SIZE);
        header_seen <= 1'b0;
        if (foot_ok) begin
          // Swap banks instead of copying the message.
          pub_bank        <= ~pub_bank;
          message_present <= 1'b1;
        end
      end else begin
        fill_index  <= fill_sum[FILL_W-1:0];
        header_seen <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage one
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_is_read <= (in_data.mode == MODE_READ);
      s1_status  <= frame_status;
      s1_rd_ok   <= message_present && in_range;
      s1_lo_lane <= rpos[2:0];
      s1_hi_lane <= rpos1[2:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_comb begin
    dist_word = s1_rd_ok ? {rdata[s1_hi_lane], rdata[s1_lo_lane]} : 16'd0;
    dist_ok   = s1_rd_ok && (dist_word != DIST_INVALID) && (dist_word >= min_distance);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      if (s1_is_read) begin
        out_data.status         <= STATUS_SECTOR;
        out_data.distance_raw   <= dist_word;
        out_data.distance_valid <= dist_ok;
      end else begin
        out_data.status         <= s1_status;
        out_data.distance_raw   <= 16'd0;
        out_data.distance_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `CLFR_ASSERT_ALWAYS(a_fill_open, !header_seen || (fill_index < FILL_W'(MSG_SIZE)), "fill at end")
  `CLFR_ASSERT_NEXT(a_pub_swap, pub_fire, message_present && (pub_bank != $past(pub_bank)), "no swap")
  `CLFR_ASSERT_ALWAYS(a_valid_sector, !out_valid || !out_data.distance_valid || (out_data.status == STATUS_SECTOR), "valid on frame")
  `CLFR_ASSERT_NEXT(a_s1_hold, s1_valid && !s1_move, s1_valid, "stage one word dropped")

endmodule
